// File: design/gcodelp_pkg.sv
// package: codes, widths and helper functions for the g-code line parser
package gcodelp_pkg;

	localparam int CHAR_W    = 8;
	localparam int STATUS_W  = 3;
	localparam int KIND_W    = 2;
	localparam int CODE_W    = 19;
	localparam int VALUE_W   = 29;
	localparam int AXES      = 4;
	localparam int WHOLE_W   = 21;
	localparam int FRAC_W    = 10;
	localparam int FDIG_W    = 2;
	localparam int MAG_W     = 28;
	localparam int SUM_W     = 9;
	localparam int SUMX_W    = 12;

	localparam logic [WHOLE_W-1:0] WholeLimit = WHOLE_W'(200000);
	localparam logic [MAG_W-1:0]   Milli      = MAG_W'(1000);
	localparam logic [FDIG_W-1:0]  FracDigits = FDIG_W'(3);
	localparam logic [SUM_W-1:0]   SumSat     = SUM_W'(256);

	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UZ     = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LZ     = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_MASK = 8'hDF;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_CHECKSUM    = 3'd1,
		ST_INVALID     = 3'd2,
		ST_UNSUPPORTED = 3'd3,
		ST_UNKNOWN     = 3'd4
	} status_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE = 2'd0,
		KIND_G    = 2'd1,
		KIND_M    = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_BETWEEN,
		PH_SIGN,
		PH_WHOLE,
		PH_FRAC,
		PH_COMMENT
	} phase_t;

	typedef enum logic [3:0] {
		L_N,
		L_G,
		L_M,
		L_X,
		L_Y,
		L_Z,
		L_E,
		L_F,
		L_OTHER
	} letter_t;

	typedef enum logic [1:0] {
		STAR_NONE,
		STAR_SEEN,
		STAR_DIGITS,
		STAR_DONE
	} star_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_letter(input logic [CHAR_W-1:0] c);
		return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
	endfunction

	function automatic letter_t letter_code(input logic [CHAR_W-1:0] c);
		letter_t l;
		case (c & CASE_MASK)
			8'h4E: l = L_N;
			8'h47: l = L_G;
			8'h4D: l = L_M;
			8'h58: l = L_X;
			8'h59: l = L_Y;
			8'h5A: l = L_Z;
			8'h45: l = L_E;
			8'h46: l = L_F;
			default: l = L_OTHER;
		endcase
		return l;
	endfunction

endpackage

// File: design/gcodelp_char_if.sv
// interface: character item channel into the parser
interface gcodelp_char_if;
	logic                              valid;
	logic                              ready;
	logic [gcodelp_pkg::CHAR_W-1:0]    char_in;
	logic                              end_of_line;

	modport source (output valid, output char_in, output end_of_line, input ready);
	modport sink   (input valid, input char_in, input end_of_line, output ready);
endinterface

// File: design/gcodelp_result_if.sv
// interface: parse result item channel out of the parser
interface gcodelp_result_if;
	logic                                   valid;
	logic                                   ready;
	logic [gcodelp_pkg::STATUS_W-1:0]       status;
	logic [gcodelp_pkg::KIND_W-1:0]         code_kind;
	logic signed [gcodelp_pkg::CODE_W-1:0]  code_number;
	logic signed [gcodelp_pkg::VALUE_W-1:0] x_value;
	logic signed [gcodelp_pkg::VALUE_W-1:0] y_value;
	logic signed [gcodelp_pkg::VALUE_W-1:0] z_value;
	logic signed [gcodelp_pkg::VALUE_W-1:0] e_value;
	logic [gcodelp_pkg::AXES-1:0]           axis_present;
	logic signed [gcodelp_pkg::VALUE_W-1:0] feed_value;
	logic                                   feed_present;

	modport source (output valid, output status, output code_kind, output code_number,
		output x_value, output y_value, output z_value, output e_value,
		output axis_present, output feed_value, output feed_present, input ready);
	modport sink (input valid, input status, input code_kind, input code_number,
		input x_value, input y_value, input z_value, input e_value,
		input axis_present, input feed_value, input feed_present, output ready);
endinterface

// File: design/gcode_line_parser_core.sv
// g-code line parser: per-character word scanner, checksum and result register
// path: an end-of-line item goes from the input register to the result register
// throughput: one character or end-of-line item per cycle while no end-of-line item is held,
//   limited by the single per-character update of the scan state between input and result registers
// a result waiting in the output register stalls only end-of-line items
// reset (arst_n low, asynchronous): line state cleared, both stages empty
module gcode_line_parser_core (
	input  logic                    clk,
	input  logic                    arst_n,
	gcodelp_char_if.sink            line_chars,
	gcodelp_result_if.source        parse_result
);
	import gcodelp_pkg::*;

	// input register stage
	logic              vld_s1;
	logic [CHAR_W-1:0] chr_s1;
	logic              eol_s1;
	logic              fire;

	// line scan state
	phase_t                   phase_q, phase_d;
	letter_t                  letter_q, letter_d;
	logic                     neg_q, neg_d;
	logic [WHOLE_W-1:0]       whole_q, whole_d;
	logic [FRAC_W-1:0]        frac_q, frac_d;
	logic [FDIG_W-1:0]        fdig_q, fdig_d;
	logic                     dseen_q, dseen_d;
	logic                     stopped_q, stopped_d;
	logic                     closed_q, closed_d;
	status_t                  err_q, err_d;
	kind_t                    kind_q, kind_d;
	logic signed [CODE_W-1:0] code_q, code_d;
	logic [VALUE_W-1:0]       axis_q [AXES];
	logic [VALUE_W-1:0]       axis_d [AXES];
	logic [AXES-1:0]          aflag_q, aflag_d;
	logic [VALUE_W-1:0]       feed_q, feed_d;
	logic                     fflag_q, fflag_d;

	// checksum state
	logic [CHAR_W-1:0]        xor_q, xor_d;
	star_t                    star_q, star_d;
	logic [SUM_W-1:0]         sum_q, sum_d;
	logic [SUMX_W-1:0]        sum_ext;

	// output register
	logic                     out_vld_q;
	status_t                  res_status;
	logic                     res_ok;
	logic                     sum_bad;

	// word finish datapath, from the current scan registers
	logic [FRAC_W-1:0]        f_scaled;
	logic [MAG_W-1:0]         mag;
	logic [VALUE_W-1:0]       word_val;
	logic                     fin_bad;
	logic                     in_number;

	// per-item control decisions
	logic                     do_fin;
	logic                     do_between;
	logic                     stop_after;
	logic                     is_eol_item;
	logic [3:0]               dig;

	// line values after the final word closes, before the end-of-line clear
	kind_t                    kind_fin;
	logic signed [CODE_W-1:0] code_fin;
	logic [VALUE_W-1:0]       axis_fin [AXES];
	logic [AXES-1:0]          aflag_fin;
	logic [VALUE_W-1:0]       feed_fin;
	logic                     fflag_fin;

	// an end-of-line item needs a free output register; characters never wait
	assign fire = vld_s1 && (!eol_s1 || !out_vld_q || parse_result.ready);
	assign line_chars.ready = !vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (line_chars.ready) begin
			vld_s1 <= line_chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line_chars.ready && line_chars.valid) begin
			chr_s1 <= line_chars.char_in;
			eol_s1 <= line_chars.end_of_line;
		end
	end

	// fraction digits scaled to thousandths, then magnitude and sign
	always_comb begin
		case (fdig_q)
			2'd1: f_scaled = FRAC_W'(frac_q * FRAC_W'(100));
			2'd2: f_scaled = FRAC_W'(frac_q * FRAC_W'(10));
			2'd3: f_scaled = frac_q;
			default: f_scaled = '0;
		endcase
	end

	assign mag      = MAG_W'(whole_q) * Milli + MAG_W'(f_scaled);
	assign word_val = neg_q ? -VALUE_W'(mag) : VALUE_W'(mag);
	assign fin_bad  = !dseen_q || (whole_q > WholeLimit);
	assign in_number = (phase_q == PH_SIGN) || (phase_q == PH_WHOLE) || (phase_q == PH_FRAC);
	assign dig      = 4'(chr_s1 - CH_ZERO);
	assign sum_ext  = SUMX_W'(sum_q) * SUMX_W'(10) + SUMX_W'(dig);

	// checksum fails when a star has no digit after it or the digits mismatch
	assign sum_bad = (star_q == STAR_SEEN) ||
		(((star_q == STAR_DIGITS) || (star_q == STAR_DONE)) && (sum_q != SUM_W'(xor_q)));

	always_comb begin
		phase_d   = phase_q;
		letter_d  = letter_q;
		neg_d     = neg_q;
		whole_d   = whole_q;
		frac_d    = frac_q;
		fdig_d    = fdig_q;
		dseen_d   = dseen_q;
		stopped_d = stopped_q;
		closed_d  = closed_q;
		err_d     = err_q;
		kind_d    = kind_q;
		code_d    = code_q;
		axis_d    = axis_q;
		aflag_d   = aflag_q;
		feed_d    = feed_q;
		fflag_d   = fflag_q;
		xor_d     = xor_q;
		star_d    = star_q;
		sum_d     = sum_q;
		do_fin     = 1'b0;
		do_between = 1'b0;
		stop_after = 1'b0;
		is_eol_item = 1'b0;

		if (fire) begin
			if (eol_s1) begin
				is_eol_item = 1'b1;
				do_fin = !stopped_q && in_number;
			end else if (!closed_q) begin
				if (chr_s1 == CH_NUL) begin
					// nul closes the line: finish any open word, ignore the rest
					closed_d   = 1'b1;
					do_fin     = !stopped_q && in_number;
					stop_after = 1'b1;
				end else begin
					// checksum runs on every character, even after a parse stop
					case (star_q)
						STAR_NONE: begin
							if (chr_s1 == CH_STAR) star_d = STAR_SEEN;
							else xor_d = xor_q ^ chr_s1;
						end
						STAR_SEEN: begin
							if (is_digit(chr_s1)) begin
								sum_d  = SUM_W'(dig);
								star_d = STAR_DIGITS;
							end else begin
								sum_d  = SumSat;
								star_d = STAR_DONE;
							end
						end
						STAR_DIGITS: begin
							if (is_digit(chr_s1)) begin
								sum_d = (sum_ext > SUMX_W'(SumSat)) ? SumSat : SUM_W'(sum_ext);
							end else begin
								star_d = STAR_DONE;
							end
						end
						default: ;
					endcase

					if (!stopped_q) begin
						case (phase_q)
							PH_COMMENT: begin
								if (chr_s1 == CH_RPAREN) phase_d = PH_BETWEEN;
							end
							PH_SIGN, PH_WHOLE: begin
								phase_d = PH_WHOLE;
								if ((phase_q == PH_SIGN) &&
									((chr_s1 == CH_PLUS) || (chr_s1 == CH_MINUS))) begin
									neg_d = (chr_s1 == CH_MINUS);
								end else if (is_digit(chr_s1)) begin
									dseen_d = 1'b1;
									whole_d = WHOLE_W'(whole_q * WHOLE_W'(10) + WHOLE_W'(dig));
									if (whole_d > WholeLimit) begin
										if (err_d == ST_OK) err_d = ST_INVALID;
										stopped_d = 1'b1;
									end
								end else if (chr_s1 == CH_DOT) begin
									phase_d = PH_FRAC;
								end else begin
									do_fin     = 1'b1;
									do_between = 1'b1;
								end
							end
							PH_FRAC: begin
								if (is_digit(chr_s1)) begin
									dseen_d = 1'b1;
									// digits past the third are dropped
									if (fdig_q < FracDigits) begin
										frac_d = FRAC_W'(frac_q * FRAC_W'(10) + FRAC_W'(dig));
										fdig_d = fdig_q + 2'd1;
									end
								end else begin
									do_fin     = 1'b1;
									do_between = 1'b1;
								end
							end
							default: do_between = 1'b1;
						endcase
					end
				end
			end
		end

		// close the open word
		if (do_fin) begin
			phase_d = PH_BETWEEN;
			if (fin_bad) begin
				if (err_d == ST_OK) err_d = ST_INVALID;
				stopped_d = 1'b1;
			end else begin
				case (letter_q)
					L_N: ;
					L_G, L_M: begin
						if (kind_q != KIND_NONE) begin
							// second code word on the line
							if (err_d == ST_OK) err_d = ST_INVALID;
							stopped_d = 1'b1;
						end else if (f_scaled != '0) begin
							if (err_d == ST_OK) err_d = ST_UNSUPPORTED;
							stopped_d = 1'b1;
						end else begin
							kind_d = (letter_q == L_G) ? KIND_G : KIND_M;
							code_d = neg_q ? -CODE_W'(whole_q) : CODE_W'(whole_q);
						end
					end
					L_X: begin aflag_d[0] = 1'b1; axis_d[0] = word_val; end
					L_Y: begin aflag_d[1] = 1'b1; axis_d[1] = word_val; end
					L_Z: begin aflag_d[2] = 1'b1; axis_d[2] = word_val; end
					L_E: begin aflag_d[3] = 1'b1; axis_d[3] = word_val; end
					L_F: begin fflag_d = 1'b1; feed_d = word_val; end
					default: begin
						// unknown letter, flagged only once its number parsed
						if (err_d == ST_OK) err_d = ST_UNKNOWN;
						stopped_d = 1'b1;
					end
				endcase
			end
		end

		// between words: blanks, stops, comments, a new letter or a stray character
		if (do_between && !stopped_d) begin
			if ((chr_s1 == CH_SPACE) || (chr_s1 == CH_TAB)) begin
				phase_d = PH_BETWEEN;
			end else if ((chr_s1 == CH_SEMI) || (chr_s1 == CH_STAR)) begin
				stopped_d = 1'b1;
			end else if (chr_s1 == CH_LPAREN) begin
				phase_d = PH_COMMENT;
			end else if (is_letter(chr_s1)) begin
				letter_d = letter_code(chr_s1);
				neg_d    = 1'b0;
				whole_d  = '0;
				frac_d   = '0;
				fdig_d   = '0;
				dseen_d  = 1'b0;
				phase_d  = PH_SIGN;
			end else begin
				if (err_d == ST_OK) err_d = ST_INVALID;
				stopped_d = 1'b1;
			end
		end

		if (stop_after) stopped_d = 1'b1;

		// result status: checksum failure outranks the first parse error
		res_status = sum_bad ? ST_CHECKSUM : err_d;
		res_ok     = (res_status == ST_OK);

		// end of line starts a fresh line
		if (is_eol_item) begin
			phase_d   = PH_BETWEEN;
			letter_d  = L_N;
			neg_d     = 1'b0;
			whole_d   = '0;
			frac_d    = '0;
			fdig_d    = '0;
			dseen_d   = 1'b0;
			stopped_d = 1'b0;
			closed_d  = 1'b0;
			err_d     = ST_OK;
			kind_d    = KIND_NONE;
			code_d    = '0;
			for (int i = 0; i < AXES; i++) axis_d[i] = '0;
			aflag_d   = '0;
			feed_d    = '0;
			fflag_d   = 1'b0;
			xor_d     = '0;
			star_d    = STAR_NONE;
			sum_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_BETWEEN;
			letter_q  <= L_N;
			neg_q     <= 1'b0;
			whole_q   <= '0;
			frac_q    <= '0;
			fdig_q    <= '0;
			dseen_q   <= 1'b0;
			stopped_q <= 1'b0;
			closed_q  <= 1'b0;
			err_q     <= ST_OK;
			kind_q    <= KIND_NONE;
			code_q    <= '0;
			for (int i = 0; i < AXES; i++) axis_q[i] <= '0;
			aflag_q   <= '0;
			feed_q    <= '0;
			fflag_q   <= 1'b0;
			xor_q     <= '0;
			star_q    <= STAR_NONE;
			sum_q     <= '0;
		end else begin
			phase_q   <= phase_d;
			letter_q  <= letter_d;
			neg_q     <= neg_d;
			whole_q   <= whole_d;
			frac_q    <= frac_d;
			fdig_q    <= fdig_d;
			dseen_q   <= dseen_d;
			stopped_q <= stopped_d;
			closed_q  <= closed_d;
			err_q     <= err_d;
			kind_q    <= kind_d;
			code_q    <= code_d;
			axis_q    <= axis_d;
			aflag_q   <= aflag_d;
			feed_q    <= feed_d;
			fflag_q   <= fflag_d;
			xor_q     <= xor_d;
			star_q    <= star_d;
			sum_q     <= sum_d;
		end
	end

	// result register: loaded from the state as it stands after the last word closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (is_eol_item) begin
			out_vld_q <= 1'b1;
		end else if (parse_result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_eol_item) begin
			parse_result.status       <= res_status;
			parse_result.code_kind    <= res_ok ? kind_fin : KIND_NONE;
			parse_result.code_number  <= res_ok ? code_fin : '0;
			parse_result.x_value      <= res_ok ? axis_fin[0] : '0;
			parse_result.y_value      <= res_ok ? axis_fin[1] : '0;
			parse_result.z_value      <= res_ok ? axis_fin[2] : '0;
			parse_result.e_value      <= res_ok ? axis_fin[3] : '0;
			parse_result.axis_present <= res_ok ? aflag_fin : '0;
			parse_result.feed_value   <= res_ok ? feed_fin : '0;
			parse_result.feed_present <= res_ok && fflag_fin;
		end
	end

	assign parse_result.valid = out_vld_q;

	// line values after the final word closes, before the end-of-line clear
	always_comb begin
		kind_fin  = kind_q;
		code_fin  = code_q;
		axis_fin  = axis_q;
		aflag_fin = aflag_q;
		feed_fin  = feed_q;
		fflag_fin = fflag_q;
		if (do_fin && !fin_bad) begin
			case (letter_q)
				L_G, L_M: begin
					if ((kind_q == KIND_NONE) && (f_scaled == '0)) begin
						kind_fin = (letter_q == L_G) ? KIND_G : KIND_M;
						code_fin = neg_q ? -CODE_W'(whole_q) : CODE_W'(whole_q);
					end
				end
				L_X: begin aflag_fin[0] = 1'b1; axis_fin[0] = word_val; end
				L_Y: begin aflag_fin[1] = 1'b1; axis_fin[1] = word_val; end
				L_Z: begin aflag_fin[2] = 1'b1; axis_fin[2] = word_val; end
				L_E: begin aflag_fin[3] = 1'b1; axis_fin[3] = word_val; end
				L_F: begin fflag_fin = 1'b1; feed_fin = word_val; end
				default: ;
			endcase
		end
	end

endmodule

// File: bench/tb_gcode_line_parser_core.sv
// testbench: g-code line parser driven with directed and random lines, checked against a line predictor
`timescale 1ns / 1ps

module tb_gcode_line_parser_core;
	import gcodelp_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_REPORTS  = 10;

	// how a test line ends: no checksum, a right one, a wrong one, a star with no digit
	typedef enum {SUM_OFF, SUM_RIGHT, SUM_WRONG, SUM_NO_DIGIT} sum_tail_t;

	typedef bit [CHAR_W-1:0] char_q_t[$];

	// one parsed line as the result channel reports it
	typedef struct {
		status_t              status;
		logic [KIND_W-1:0]    kind;
		logic [CODE_W-1:0]    code;
		logic [VALUE_W-1:0]   x;
		logic [VALUE_W-1:0]   y;
		logic [VALUE_W-1:0]   z;
		logic [VALUE_W-1:0]   e;
		logic [AXES-1:0]      axes;
		logic [VALUE_W-1:0]   feed;
		logic                 feed_on;
	} line_result_t;

	logic clk = 1'b0;
	logic arst_n;

	gcodelp_char_if   chars_if();
	gcodelp_result_if res_if();

	gcode_line_parser_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.line_chars   (chars_if),
		.parse_result (res_if)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// parsed lines still waiting to come out of the block
	line_result_t pending_results[$];

	int send_idle;
	int recv_idle;
	int stall_left;
	int items_sent;
	int mismatch_count;
	int cycle_count;

	// ------------------------------------------------------------------
	// line predictor: word scanner, checksum tracker and the line summary
	// ------------------------------------------------------------------
	phase_t                scan_ph;
	letter_t               cur_letter;
	bit                    num_neg;
	int unsigned           whole_acc;
	int unsigned           frac_acc;
	int unsigned           frac_cnt;
	bit                    got_digit;
	bit                    halted;        // parsing over, only the checksum still listens
	bit                    content_over;  // a nul byte ended the line content
	status_t               first_err;
	kind_t                 seen_kind;
	int                    seen_code;
	int                    axis_val[AXES];
	bit [AXES-1:0]         axis_seen;
	int                    feed_val;
	bit                    feed_seen;
	bit [CHAR_W-1:0]       line_xor;
	star_t                 star_ph;
	int unsigned           sum_given;

	function automatic void clear_line_state();
		scan_ph      = PH_BETWEEN;
		cur_letter   = L_N;
		num_neg      = 1'b0;
		whole_acc    = 0;
		frac_acc     = 0;
		frac_cnt     = 0;
		got_digit    = 1'b0;
		halted       = 1'b0;
		content_over = 1'b0;
		first_err    = ST_OK;
		seen_kind    = KIND_NONE;
		seen_code    = 0;
		foreach (axis_val[i]) axis_val[i] = 0;
		axis_seen    = '0;
		feed_val     = 0;
		feed_seen    = 1'b0;
		line_xor     = '0;
		star_ph      = STAR_NONE;
		sum_given    = 0;
	endfunction

	// the first error of a line sticks, and any error stops the scan
	function automatic void raise_error(status_t err);
		if (first_err == ST_OK) first_err = err;
		halted = 1'b1;
	endfunction

	function automatic bit digit_char(bit [CHAR_W-1:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit alpha_char(bit [CHAR_W-1:0] c);
		return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
	endfunction

	function automatic letter_t word_code(bit [CHAR_W-1:0] c);
		bit [CHAR_W-1:0] upper;
		upper = (c >= CH_LA) ? c - (CH_LA - CH_UA) : c;
		case (upper)
			"N": return L_N;
			"G": return L_G;
			"M": return L_M;
			"X": return L_X;
			"Y": return L_Y;
			"Z": return L_Z;
			"E": return L_E;
			"F": return L_F;
			default: return L_OTHER;
		endcase
	endfunction

	// a word's number has ended: scale it to thousandths and file it under its letter
	function automatic void close_word();
		int unsigned scaled;
		int unsigned mag;
		int unsigned d;
		int          val;
		scaled = frac_acc;
		scan_ph = PH_BETWEEN;
		if (!got_digit || whole_acc > WholeLimit) begin
			raise_error(ST_INVALID);
			return;
		end
		for (d = frac_cnt; d < FracDigits; d++) scaled = scaled * 10;
		mag = whole_acc * Milli + scaled;
		val = num_neg ? -int'(mag) : int'(mag);
		case (cur_letter)
			L_N: ;
			L_G, L_M: begin
				if (seen_kind != KIND_NONE) begin
					raise_error(ST_INVALID);
					return;
				end
				if (scaled != 0) begin
					raise_error(ST_UNSUPPORTED);
					return;
				end
				seen_kind = (cur_letter == L_G) ? KIND_G : KIND_M;
				seen_code = num_neg ? -int'(whole_acc) : int'(whole_acc);
			end
			L_X: begin axis_seen[0] = 1'b1; axis_val[0] = val; end
			L_Y: begin axis_seen[1] = 1'b1; axis_val[1] = val; end
			L_Z: begin axis_seen[2] = 1'b1; axis_val[2] = val; end
			L_E: begin axis_seen[3] = 1'b1; axis_val[3] = val; end
			L_F: begin feed_seen = 1'b1; feed_val = val; end
			default: raise_error(ST_UNKNOWN);
		endcase
	endfunction

	// character seen while no word is open
	function automatic void gap_char(bit [CHAR_W-1:0] c);
		if (c == CH_SPACE || c == CH_TAB) return;
		if (c == CH_SEMI || c == CH_STAR) begin
			halted = 1'b1;
			return;
		end
		if (c == CH_LPAREN) begin
			scan_ph = PH_COMMENT;
			return;
		end
		if (alpha_char(c)) begin
			cur_letter = word_code(c);
			num_neg    = 1'b0;
			whole_acc  = 0;
			frac_acc   = 0;
			frac_cnt   = 0;
			got_digit  = 1'b0;
			scan_ph    = PH_SIGN;
			return;
		end
		raise_error(ST_INVALID);
	endfunction

	// xor of everything before the first star, then the decimal number after it
	function automatic void sum_char(bit [CHAR_W-1:0] c);
		case (star_ph)
			STAR_NONE: begin
				if (c == CH_STAR) star_ph = STAR_SEEN;
				else line_xor ^= c;
			end
			STAR_SEEN: begin
				if (digit_char(c)) begin
					sum_given = c - CH_ZERO;
					star_ph = STAR_DIGITS;
				end else begin
					sum_given = SumSat;
					star_ph = STAR_DONE;
				end
			end
			STAR_DIGITS: begin
				if (digit_char(c)) begin
					sum_given = sum_given * 10 + (c - CH_ZERO);
					if (sum_given > SumSat) sum_given = SumSat;
				end else begin
					star_ph = STAR_DONE;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void scan_char(bit [CHAR_W-1:0] c);
		case (scan_ph)
			PH_COMMENT: begin
				if (c == CH_RPAREN) scan_ph = PH_BETWEEN;
			end
			PH_SIGN, PH_WHOLE: begin
				// a sign is only taken right after the letter
				if (scan_ph == PH_SIGN) begin
					scan_ph = PH_WHOLE;
					if (c == CH_PLUS || c == CH_MINUS) begin
						num_neg = (c == CH_MINUS);
						return;
					end
				end
				if (digit_char(c)) begin
					got_digit = 1'b1;
					whole_acc = whole_acc * 10 + (c - CH_ZERO);
					if (whole_acc > WholeLimit) raise_error(ST_INVALID);
					return;
				end
				if (c == CH_DOT) begin
					scan_ph = PH_FRAC;
					return;
				end
				close_word();
				if (!halted) gap_char(c);
			end
			PH_FRAC: begin
				if (digit_char(c)) begin
					// digits past the third are dropped
					got_digit = 1'b1;
					if (frac_cnt < FracDigits) begin
						frac_acc = frac_acc * 10 + (c - CH_ZERO);
						frac_cnt++;
					end
					return;
				end
				close_word();
				if (!halted) gap_char(c);
			end
			default: gap_char(c);
		endcase
	endfunction

	function automatic bit word_open();
		return scan_ph == PH_SIGN || scan_ph == PH_WHOLE || scan_ph == PH_FRAC;
	endfunction

	// one accepted item: characters update the line, end of line queues its result
	function automatic void predict_item(bit [CHAR_W-1:0] c, bit eol);
		line_result_t res;
		status_t      st;
		bit           ok;
		if (!eol) begin
			if (content_over) return;
			if (c == CH_NUL) begin
				content_over = 1'b1;
				if (!halted && word_open()) close_word();
				halted = 1'b1;
				return;
			end
			sum_char(c);
			if (!halted) scan_char(c);
			return;
		end
		if (!halted && word_open()) close_word();
		// a bad checksum outranks whatever the scan found
		if (star_ph == STAR_SEEN || (star_ph >= STAR_DIGITS && sum_given != line_xor))
			st = ST_CHECKSUM;
		else
			st = first_err;
		ok = (st == ST_OK);
		res.status  = st;
		res.kind    = ok ? seen_kind : KIND_NONE;
		res.code    = ok ? CODE_W'(seen_code) : '0;
		res.x       = ok ? VALUE_W'(axis_val[0]) : '0;
		res.y       = ok ? VALUE_W'(axis_val[1]) : '0;
		res.z       = ok ? VALUE_W'(axis_val[2]) : '0;
		res.e       = ok ? VALUE_W'(axis_val[3]) : '0;
		res.axes    = ok ? axis_seen : '0;
		res.feed    = ok ? VALUE_W'(feed_val) : '0;
		res.feed_on = ok && feed_seen;
		pending_results.push_back(res);
		clear_line_state();
	endfunction

	// ------------------------------------------------------------------
	// line building and sending
	// ------------------------------------------------------------------
	function automatic char_q_t text_bytes(string s);
		char_q_t q;
		int      i;
		for (i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	function automatic void add_checksum(ref char_q_t q, input sum_tail_t tail);
		bit [CHAR_W-1:0] line_sum;
		int              value;
		line_sum = '0;
		foreach (q[i]) begin
			if (q[i] == CH_STAR) break;
			line_sum ^= q[i];
		end
		case (tail)
			SUM_OFF: return;
			SUM_RIGHT: value = line_sum;
			// never equal; past 255 it also tests saturation
			SUM_WRONG: value = line_sum + 1 + $urandom_range(0, 50);
			default: begin
				q.push_back(CH_STAR);
				if ($urandom_range(0, 1) == 1) q.push_back(CH_SPACE);
				return;
			end
		endcase
		q.push_back(CH_STAR);
		q = {q, text_bytes($sformatf("%0d", value))};
	endfunction

	// one item over the character channel; called and returning at a falling edge
	task automatic send_item(input bit [CHAR_W-1:0] c, input bit eol);
		while ($urandom_range(0, 99) < send_idle) begin
			chars_if.valid <= 1'b0;
			@(negedge clk);
		end
		chars_if.valid       <= 1'b1;
		chars_if.char_in     <= c;
		chars_if.end_of_line <= eol;
		@(posedge clk);
		while (chars_if.ready !== 1'b1) @(posedge clk);
		predict_item(c, eol);
		items_sent++;
		@(negedge clk);
	endtask

	// the characters, then end of line with a junk character that must be ignored
	task automatic send_line(input char_q_t q);
		foreach (q[i]) send_item(q[i], 1'b0);
		send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_text(input string s, input sum_tail_t tail);
		char_q_t q;
		q = text_bytes(s);
		add_checksum(q, tail);
		send_line(q);
	endtask

	// mostly well-formed words with random values, some noise and broken lines
	task automatic build_random_line(output char_q_t q);
		int              shape;
		int              r;
		int              pick;
		bit              code_word;
		bit [CHAR_W-1:0] letter;
		sum_tail_t       tail;
		string           word_letters;
		word_letters = "NGMXYZEFXYZEFXYEQ";
		q = {};
		shape = $urandom_range(0, 99);
		if (shape < 8) begin
			// raw bytes, all values
			repeat ($urandom_range(1, 20)) q.push_back(CHAR_W'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 5)) begin
			letter = word_letters[$urandom_range(0, word_letters.len() - 1)];
			code_word = (letter == "G" || letter == "M");
			if ($urandom_range(0, 3) == 0) letter = letter | ~CASE_MASK;
			q.push_back(letter);
			r = $urandom_range(0, 9);
			if (r < 3) q.push_back(CH_MINUS);
			else if (r == 3) q.push_back(CH_PLUS);
			r = $urandom_range(0, 99);
			if (r >= 5) begin
				if ($urandom_range(0, 19) == 0) q.push_back(CH_ZERO);
				if (r < 10)
					q = {q, text_bytes($sformatf("%0d", $urandom_range(199990, 200010)))};
				else if (r < 22)
					q = {q, text_bytes($sformatf("%0d", $urandom_range(0, 200000)))};
				else
					q = {q, text_bytes($sformatf("%0d", $urandom_range(0, 999)))};
			end
			// code words mostly stay integer
			if ($urandom_range(0, 99) >= (code_word ? 85 : 50)) begin
				q.push_back(CH_DOT);
				repeat ($urandom_range(0, 5))
					q.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
			end
			r = $urandom_range(0, 9);
			if (r == 2) q.push_back(CH_TAB);
			else if (r == 3) q = {q, text_bytes("  ")};
			else if (r > 3) q.push_back(CH_SPACE);
		end
		if ($urandom_range(0, 9) == 0) begin
			q.push_back(CH_LPAREN);
			repeat ($urandom_range(0, 8)) q.push_back(CHAR_W'($urandom_range(32, 126)));
			if ($urandom_range(0, 4) != 0) q.push_back(CH_RPAREN);
		end
		if ($urandom_range(0, 11) == 0) begin
			q.push_back(CH_SEMI);
			q = {q, text_bytes(" note")};
		end
		if (shape >= 82) begin
			// one stray byte somewhere, sometimes a nul
			pick = $urandom_range(0, q.size());
			q.insert(pick, ($urandom_range(0, 5) == 0) ? CH_NUL : CHAR_W'($urandom_range(0, 255)));
		end
		r = $urandom_range(0, 99);
		if (r < 45) tail = SUM_OFF;
		else if (r < 85) tail = SUM_RIGHT;
		else if (r < 95) tail = SUM_WRONG;
		else tail = SUM_NO_DIGIT;
		add_checksum(q, tail);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_word_values();
		send_text("", SUM_OFF);
		send_text("G1 X10.5 Y-3.25 Z+0.001 E2 F1500", SUM_OFF);
		send_text("m104 e-.5 f.75 n12", SUM_OFF);
		send_text("X200000.999Y-200000.999\tZ0 E-0", SUM_OFF);
		send_text("Z1.23456 X1 X-2", SUM_OFF);
		send_text("G-7 F-1", SUM_OFF);
	endtask

	task automatic test_word_errors();
		send_text("X200001", SUM_OFF);
		send_text("G1.5 Q", SUM_OFF);
		send_text("M2.000 G1", SUM_OFF);
		send_text("Q5", SUM_OFF);
		send_text("Q", SUM_OFF);
		send_text("X-", SUM_OFF);
		send_text("X.", SUM_OFF);
		send_text("X 5", SUM_OFF);
		send_text("G1 #", SUM_OFF);
		send_text("X1..2", SUM_OFF);
	endtask

	task automatic test_comments_and_stops();
		send_text("G1 (move) X2 (open", SUM_OFF);
		send_text("(a)(b)M3", SUM_OFF);
		send_text("G28 ;X5", SUM_OFF);
		send_text("\tX1\tY2 ;tail", SUM_OFF);
	endtask

	task automatic test_checksum();
		send_text("N3 G1 X5", SUM_RIGHT);
		send_text("G1 X5", SUM_WRONG);
		send_text("G1", SUM_NO_DIGIT);
		send_text("G1*999", SUM_OFF);
		send_text("G1*00118", SUM_OFF);
		send_text("Q1 #", SUM_WRONG);
		send_text("Q1", SUM_RIGHT);
		// a star inside a comment still starts the check
		send_text("(c*7) G1", SUM_OFF);
	endtask

	// a nul byte ends the content: nothing after it counts, not even a star
	task automatic test_nul_byte();
		char_q_t q;
		q = text_bytes("G1 X1");
		q.push_back(CH_NUL);
		q = {q, text_bytes("2 *9")};
		send_line(q);
		q = text_bytes("(ab");
		q.push_back(CH_NUL);
		q = {q, text_bytes(")X3")};
		send_line(q);
		q = {};
		q.push_back(CH_NUL);
		q = {q, text_bytes("Q#")};
		send_line(q);
	endtask

	// receiver holds off while lines keep coming, so end-of-line items back up
	task automatic test_output_backpressure();
		char_q_t q;
		send_idle = 0;
		recv_idle = 53;
		stall_left = HOLD_CYCLES;
		repeat (12) begin
			build_random_line(q);
			send_line(q);
		end
	endtask

	task automatic test_random_lines(input int tx_idle, input int rx_idle, input int count);
		char_q_t q;
		int      stop_at;
		send_idle = tx_idle;
		recv_idle = rx_idle;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			build_random_line(q);
			send_line(q);
		end
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------
	initial begin : receiver
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_if.ready <= 1'b0;
				stall_left--;
			end else begin
				res_if.ready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		line_result_t got;
		line_result_t want;
		if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			got.status  = status_t'(res_if.status);
			got.kind    = res_if.code_kind;
			got.code    = res_if.code_number;
			got.x       = res_if.x_value;
			got.y       = res_if.y_value;
			got.z       = res_if.z_value;
			got.e       = res_if.e_value;
			got.axes    = res_if.axis_present;
			got.feed    = res_if.feed_value;
			got.feed_on = res_if.feed_present;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("result item with no line pending, status 'h%0h", got.status);
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, got.status);
				check_field("code_kind", want.kind, got.kind);
				check_field("code_number", want.code, got.code);
				check_field("x_value", want.x, got.x);
				check_field("y_value", want.y, got.y);
				check_field("z_value", want.z, got.z);
				check_field("e_value", want.e, got.e);
				check_field("axis_present", want.axes, got.axes);
				check_field("feed_value", want.feed, got.feed);
				check_field("feed_present", want.feed_on, got.feed_on);
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL gcode_line_parser_core");
		$finish;
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		chars_if.valid       = 1'b0;
		chars_if.char_in     = '0;
		chars_if.end_of_line = 1'b0;
		arst_n               = 1'b0;
		send_idle            = 0;
		recv_idle            = 0;
		stall_left           = 0;
		items_sent           = 0;
		mismatch_count       = 0;
		clear_line_state();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_word_values();
		test_word_errors();
		test_comments_and_stops();
		test_checksum();
		test_nul_byte();
		test_output_backpressure();
		test_random_lines(34, 53, 300);
		test_random_lines(53, 34, 300);
		test_random_lines(0, 0, 280);
		chars_if.valid <= 1'b0;

		// drain: every line's result out, then quiet cycles before the verdict
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS gcode_line_parser_core");
		else
			$display("FAIL gcode_line_parser_core");
		$finish;
	end

endmodule
